### rtl/y2nv_pkg.sv
// ----------------------------------------------------------------------------
// y2nv_pkg
// Shared constants, register codes and types of the 4:4:4 to NV12 chroma
// downsampler.
// ----------------------------------------------------------------------------
package y2nv_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int LINE_AW    = COL_W - 1;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int PIX_W      = 8;
  localparam int PAIR_W     = PIX_W + 1;
  localparam int LINE_W     = 2 * PAIR_W;
  localparam int POS_W      = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(1920);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(1080);
  localparam logic [CFG_W-1:0] WIDTH_LIM  = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] HEIGHT_LIM = CFG_W'(MAX_HEIGHT);

  typedef struct packed {
    logic               odd_col;
    logic               odd_row;
    logic               frame_end;
    logic [LINE_AW-1:0] col_half;
    logic [ROW_W-2:0]   row_half;
    logic [PAIR_W-1:0]  cb_pair;
    logic [PAIR_W-1:0]  cr_pair;
  } scan_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/y2nv_line_ram.sv
// ----------------------------------------------------------------------------
// y2nv_line_ram
// Line store of horizontal U/V pair sums, one write or read port, registered
// read data.
// ----------------------------------------------------------------------------
module y2nv_line_ram
  import y2nv_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic               re_i,
  input  logic [LINE_AW-1:0] addr_i,
  input  logic [LINE_W-1:0]  wdata_i,
  output logic [LINE_W-1:0]  rdata_o
);

  logic [LINE_W-1:0] mem [LINE_DEPTH];
  logic [LINE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/y2nv_scan.sv
// ----------------------------------------------------------------------------
// y2nv_scan
// Frame size registers, raster position counters and the held even-column
// chroma samples; forms the pair sums of each incoming pixel.
// ----------------------------------------------------------------------------
module y2nv_scan
  import y2nv_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 advance_i,
  input  logic [PIX_W-1:0]     cb_i,
  input  logic [PIX_W-1:0]     cr_i,
  output scan_t                scan_o
);

  logic [CFG_W-1:0] width_q, height_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [PIX_W-1:0] held_cb_q, held_cr_q;
  logic [CFG_W-1:0] w_eff, h_eff;
  logic             last_col, last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_eff    = clamp_dim(width_q, WIDTH_LIM);
  assign h_eff    = clamp_dim(height_q, HEIGHT_LIM);
  assign last_col = (CFG_W'(col_q) + CFG_W'(1)) >= w_eff;
  assign last_row = (CFG_W'(row_q) + CFG_W'(1)) >= h_eff;

  always_comb begin
    col_d = col_q + COL_W'(1);
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      held_cb_q <= '0;
      held_cr_q <= '0;
    end else if (advance_i) begin
      col_q <= col_d;
      row_q <= row_d;
      if (!col_q[0]) begin
        held_cb_q <= cb_i;
        held_cr_q <= cr_i;
      end
    end
  end

  assign scan_o.odd_col   = col_q[0];
  assign scan_o.odd_row   = row_q[0];
  assign scan_o.frame_end = last_col & last_row;
  assign scan_o.col_half  = col_q[COL_W-1:1];
  assign scan_o.row_half  = row_q[ROW_W-1:1];
  assign scan_o.cb_pair   = PAIR_W'(held_cb_q) + PAIR_W'(cb_i);
  assign scan_o.cr_pair   = PAIR_W'(held_cr_q) + PAIR_W'(cr_i);

endmodule

### rtl/yuv444_to_nv12_chroma_downsample_core.sv
// ----------------------------------------------------------------------------
// yuv444_to_nv12_chroma_downsample_core
// 4:4:4 YUV to NV12 chroma downsampler with a 2x2 box filter.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on the input channel (in_valid_i/in_stall_o),
//   one transfer per pixel. Each input transfer yields exactly one output
//   transfer (out_valid_o/out_stall_i) carrying the luma sample unchanged and,
//   on odd columns of odd rows, the averaged U/V pair with its coordinates in
//   the subsampled plane; chroma fields are zero otherwise. frame_end_o marks
//   the last pixel of the frame.
//   Each input transfer passes the middle stage, then the output register; one
//   pixel per cycle is taken unless the receiver stalls, the single-port line
//   RAM taking a pair-sum write (even rows) or read (odd rows) per pixel pair.
//   Frame size is written on the cfg channel (index 0 width, 1 height), which
//   is always ready; write only while the block is idle.
//   Reset clears the position counters, held samples and pipeline valids and
//   loads 1920x1080; the line RAM is not cleared and is written before read.
//   When the receiver stalls, the output register holds, a pixel is still taken
//   into the middle stage if it is empty, and then in_stall_o rises.
// ----------------------------------------------------------------------------
module yuv444_to_nv12_chroma_downsample_core
  import y2nv_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PIX_W-1:0]     luma_in_i,
  input  logic [PIX_W-1:0]     cb_in_i,
  input  logic [PIX_W-1:0]     cr_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIX_W-1:0]     luma_out_o,
  output logic                 chroma_valid_o,
  output logic [PIX_W-1:0]     cb_avg_o,
  output logic [PIX_W-1:0]     cr_avg_o,
  output logic [POS_W-1:0]     chroma_col_o,
  output logic [POS_W-1:0]     chroma_row_o,
  output logic                 frame_end_o
);

  scan_t             scan;
  logic              in_xfer, s1_adv;
  logic              line_we, line_re;
  logic [LINE_W-1:0] line_rdata;

  logic              s1_valid_q;
  logic [PIX_W-1:0]  s1_luma_q;
  logic              s1_chroma_q;
  logic              s1_end_q;
  logic [PAIR_W-1:0] s1_cb_pair_q, s1_cr_pair_q;
  logic [POS_W-1:0]  s1_col_q, s1_row_q;

  logic              s2_valid_q;
  logic [PIX_W-1:0]  s2_luma_q, s2_cb_q, s2_cr_q;
  logic              s2_chroma_q, s2_end_q;
  logic [POS_W-1:0]  s2_col_q, s2_row_q;

  logic [PAIR_W:0]   cb_sum, cr_sum;

  assign cfg_ready_o = 1'b1;

  assign s1_adv     = !s2_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  y2nv_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (in_xfer),
    .cb_i        (cb_in_i),
    .cr_i        (cr_in_i),
    .scan_o      (scan)
  );

  assign line_we = in_xfer && scan.odd_col && !scan.odd_row;
  assign line_re = in_xfer && scan.odd_col && scan.odd_row;

  y2nv_line_ram u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .re_i    (line_re),
    .addr_i  (scan.col_half),
    .wdata_i ({scan.cb_pair, scan.cr_pair}),
    .rdata_o (line_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_luma_q    <= luma_in_i;
      s1_chroma_q  <= scan.odd_col & scan.odd_row;
      s1_end_q     <= scan.frame_end;
      s1_cb_pair_q <= scan.cb_pair;
      s1_cr_pair_q <= scan.cr_pair;
      s1_col_q     <= POS_W'(scan.col_half);
      s1_row_q     <= POS_W'(scan.row_half);
    end
  end

  assign cb_sum = (PAIR_W+1)'(line_rdata[LINE_W-1:PAIR_W]) + (PAIR_W+1)'(s1_cb_pair_q);
  assign cr_sum = (PAIR_W+1)'(line_rdata[PAIR_W-1:0]) + (PAIR_W+1)'(s1_cr_pair_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      s2_luma_q   <= s1_luma_q;
      s2_chroma_q <= s1_chroma_q;
      s2_end_q    <= s1_end_q;
      s2_cb_q     <= s1_chroma_q ? cb_sum[PAIR_W:2] : '0;
      s2_cr_q     <= s1_chroma_q ? cr_sum[PAIR_W:2] : '0;
      s2_col_q    <= s1_chroma_q ? s1_col_q : '0;
      s2_row_q    <= s1_chroma_q ? s1_row_q : '0;
    end
  end

  assign out_valid_o    = s2_valid_q;
  assign luma_out_o     = s2_luma_q;
  assign chroma_valid_o = s2_chroma_q;
  assign cb_avg_o       = s2_cb_q;
  assign cr_avg_o       = s2_cr_q;
  assign chroma_col_o   = s2_col_q;
  assign chroma_row_o   = s2_row_q;
  assign frame_end_o    = s2_end_q;

endmodule

### tb/yuv444_to_nv12_chroma_downsample_core_test.sv
// ----------------------------------------------------------------------------
// yuv444_to_nv12_chroma_downsample_core_test
// Self-checking bench for the 4:4:4 to NV12 chroma downsampler. Streams whole
// frames in raster order at many frame sizes, from the smallest block through
// trailing odd columns and rows and zero sizes to rows of up to 200 pixels,
// with random input gaps and output stalls. A scoreboard class tracks the scan
// position, the held samples and the pair-sum line, and compares each output
// transfer field by field with its prediction.
// ----------------------------------------------------------------------------
module yuv444_to_nv12_chroma_downsample_core_test;
  import y2nv_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic             chroma_ok;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last;
  } nv12_pixel_t;

  class chroma_box_tracker;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    int unsigned       col_pos;
    int unsigned       row_pos;
    logic [PIX_W-1:0]  held_cb;
    logic [PIX_W-1:0]  held_cr;
    logic [LINE_W-1:0] pair_line [LINE_DEPTH];
    nv12_pixel_t       due_pixels [$];
    int unsigned       errors;

    function new();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      col_pos    = 0;
      row_pos    = 0;
      held_cb    = '0;
      held_cr    = '0;
      errors     = 0;
      foreach (pair_line[i]) pair_line[i] = '0;
    endfunction

    function int unsigned span(logic [CFG_W-1:0] v, int unsigned hi);
      if (v == '0) begin
        return 1;
      end
      return (v > hi) ? hi : int'(v);
    endfunction

    function int unsigned frame_pixels();
      return span(width_reg, MAX_WIDTH) * span(height_reg, MAX_HEIGHT);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
      if (index == CFG_FRAME_WIDTH) begin
        width_reg = value;
      end else if (index == CFG_FRAME_HEIGHT) begin
        height_reg = value;
      end
    endfunction

    function void note_pixel(logic [PIX_W-1:0] y, logic [PIX_W-1:0] cb,
                             logic [PIX_W-1:0] cr);
      int unsigned       w;
      int unsigned       h;
      int unsigned       slot;
      logic              last_col;
      logic              last_row;
      logic [PAIR_W-1:0] cb_pair;
      logic [PAIR_W-1:0] cr_pair;
      logic [PAIR_W:0]   cb_sum;
      logic [PAIR_W:0]   cr_sum;
      nv12_pixel_t       e;
      w        = span(width_reg, MAX_WIDTH);
      h        = span(height_reg, MAX_HEIGHT);
      last_col = (col_pos + 1 >= w);
      last_row = (row_pos + 1 >= h);
      e        = '0;
      e.luma   = y;
      if ((col_pos % 2) == 0) begin
        held_cb = cb;
        held_cr = cr;
      end else begin
        cb_pair = PAIR_W'(held_cb) + PAIR_W'(cb);
        cr_pair = PAIR_W'(held_cr) + PAIR_W'(cr);
        slot    = (col_pos / 2) % LINE_DEPTH;
        if ((row_pos % 2) == 0) begin
          pair_line[slot] = {cb_pair, cr_pair};
        end else begin
          cb_sum      = {1'b0, pair_line[slot][LINE_W-1:PAIR_W]} + {1'b0, cb_pair};
          cr_sum      = {1'b0, pair_line[slot][PAIR_W-1:0]} + {1'b0, cr_pair};
          e.cb        = cb_sum[PAIR_W:2];
          e.cr        = cr_sum[PAIR_W:2];
          e.col       = POS_W'(col_pos / 2);
          e.row       = POS_W'(row_pos / 2);
          e.chroma_ok = 1'b1;
        end
      end
      e.last = last_col && last_row;
      if (last_col) begin
        col_pos = 0;
        row_pos = last_row ? 0 : row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
      due_pixels.push_back(e);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 10) begin
        $display("%0t: %s expected %0d actual %0d", $realtime, what, want, got);
      end
    endfunction

    function void check_result(nv12_pixel_t got);
      nv12_pixel_t want;
      if (due_pixels.size() == 0) begin
        flag("unexpected transfer, luma_out", 0, got.luma);
        return;
      end
      want = due_pixels.pop_front();
      if (got.luma !== want.luma) flag("luma_out", want.luma, got.luma);
      if (got.chroma_ok !== want.chroma_ok) flag("chroma_valid", want.chroma_ok, got.chroma_ok);
      if (got.cb !== want.cb) flag("cb_avg", want.cb, got.cb);
      if (got.cr !== want.cr) flag("cr_avg", want.cr, got.cr);
      if (got.col !== want.col) flag("chroma_col", want.col, got.col);
      if (got.row !== want.row) flag("chroma_row", want.row, got.row);
      if (got.last !== want.last) flag("frame_end", want.last, got.last);
    endfunction

    function int unsigned pending();
      return due_pixels.size();
    endfunction

    function void finish_check();
      nv12_pixel_t want;
      while (due_pixels.size() != 0) begin
        want = due_pixels.pop_front();
        flag("missing transfer, luma_out", want.luma, 0);
      end
    endfunction
  endclass

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     luma_in   = '0;
  logic [PIX_W-1:0]     cb_in     = '0;
  logic [PIX_W-1:0]     cr_in     = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     luma_out;
  logic                 chroma_valid;
  logic [PIX_W-1:0]     cb_avg;
  logic [PIX_W-1:0]     cr_avg;
  logic [POS_W-1:0]     chroma_col;
  logic [POS_W-1:0]     chroma_row;
  logic                 frame_end;

  bit                   tx_quiet = 1'b0;
  bit                   rx_quiet = 1'b0;
  int unsigned          random_pixels = 0;
  chroma_box_tracker    book;

  yuv444_to_nv12_chroma_downsample_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .luma_in_i      (luma_in),
    .cb_in_i        (cb_in),
    .cr_in_i        (cr_in),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .luma_out_o     (luma_out),
    .chroma_valid_o (chroma_valid),
    .cb_avg_o       (cb_avg),
    .cr_avg_o       (cr_avg),
    .chroma_col_o   (chroma_col),
    .chroma_row_o   (chroma_row),
    .frame_end_o    (frame_end)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [PIX_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= w;
    do @(posedge clk_i); while (cfg_ready !== 1'b1);
    book.write_reg(CFG_FRAME_WIDTH, w);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk_i); while (cfg_ready !== 1'b1);
    book.write_reg(CFG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] y, logic [PIX_W-1:0] cb,
                            logic [PIX_W-1:0] cr);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    luma_in  <= y;
    cb_in    <= cb;
    cr_in    <= cr;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    book.note_pixel(y, cb, cr);
  endtask

  task automatic send_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    int unsigned count;
    set_frame(w, h);
    count    = book.frame_pixels();
    tx_quiet = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);
    repeat (count) send_pixel(pick_sample(), pick_sample(), pick_sample());
    random_pixels += count;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && !out_stall) begin
      book.check_result({luma_out, chroma_valid, cb_avg, cr_avg,
                         chroma_col, chroma_row, frame_end});
    end
  end

  initial begin : receiver
    int unsigned hold;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = rx_quiet ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (out_valid !== 1'b1);
    end
  end

  initial begin : stimulus
    logic [PIX_W-1:0] grid_cb [9];
    logic [PIX_W-1:0] grid_cr [9];
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    int unsigned      k;
    book    = new();
    grid_cb = '{255, 255, 7, 255, 254, 9, 3, 4, 5};
    grid_cr = '{1, 1, 200, 1, 0, 6, 255, 0, 255};
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest frame, saturated then empty samples
    set_frame(CFG_W'(2), CFG_W'(2));
    repeat (4) send_pixel('1, '1, '1);
    repeat (4) send_pixel('0, '0, '0);

    // trailing odd column and row, truncating average
    set_frame(CFG_W'(3), CFG_W'(3));
    for (k = 0; k < 9; k++) begin
      send_pixel(PIX_W'(k * 37), grid_cb[k], grid_cr[k]);
    end

    random_pixels = 0;
    while (random_pixels < 1930) begin
      case ($urandom_range(0, 9))
        0: w = CFG_W'($urandom_range(0, 1));
        1: w = CFG_W'($urandom_range(25, 200));
        default: w = CFG_W'($urandom_range(2, 24));
      endcase
      case ($urandom_range(0, 7))
        0: h = CFG_W'($urandom_range(0, 1));
        default: h = CFG_W'($urandom_range(2, 9));
      endcase
      send_frame(w, h);
    end

    in_valid <= 1'b0;
    k = 0;
    while (k < 2000 && book.pending() != 0) begin
      @(posedge clk_i);
      k++;
    end
    repeat (4) @(posedge clk_i);
    book.finish_check();
    if (book.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
rtl/y2nv_pkg.sv
rtl/y2nv_line_ram.sv
rtl/y2nv_scan.sv
rtl/yuv444_to_nv12_chroma_downsample_core.sv
tb/yuv444_to_nv12_chroma_downsample_core_test.sv
